@@ hdl/phe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phe_pkg
// Shared types, constants and helper functions for the pose hold error block.
// ----------------------------------------------------------------------------
package phe_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned WideW   = 64;
  localparam int unsigned Steps   = 30;
  localparam int unsigned IterW   = 5;
  localparam int unsigned MulN    = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic signed [WideW-1:0] HalfPiQ29 = 64'sd843314856;
  localparam logic [16:0]             EpsQ40    = 17'd109951;
  localparam logic signed [DataW-1:0] TgtZReset = 32'sd131072;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TGT_X   = 2'd0,
    REG_TGT_Y   = 2'd1,
    REG_TGT_Z   = 2'd2,
    REG_TGT_HDG = 2'd3
  } cfg_reg_e;

  // Product order for the shared multiplier
  typedef enum logic [2:0] {
    MUL_WW = 3'd0,
    MUL_XX = 3'd1,
    MUL_YY = 3'd2,
    MUL_ZZ = 3'd3,
    MUL_WX = 3'd4,
    MUL_YZ = 3'd5,
    MUL_WZ = 3'd6,
    MUL_XY = 3'd7
  } mul_idx_e;

  typedef struct packed {
    logic             load;
    logic             mul_en;
    mul_idx_e         mul_idx;
    logic             acc_en;
    mul_idx_e         acc_idx;
    logic             thr_mul;
    logic             sel;
    logic             shr;
    logic             shl;
    logic             rot;
    logic             iter;
    logic [IterW-1:0] iter_idx;
    logic             fin;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic hi;
    logic lo;
    logic captured;
  } status_t;

  // Arctangent of 2^-i in Q3.29, rounded
  function automatic logic signed [DataW-1:0] atan_q29(input logic [IterW-1:0] idx);
    logic signed [DataW-1:0] r;
    case (idx)
      5'd0:    r = 32'sd421657428;
      5'd1:    r = 32'sd248918915;
      5'd2:    r = 32'sd131521918;
      5'd3:    r = 32'sd66762579;
      5'd4:    r = 32'sd33510843;
      5'd5:    r = 32'sd16771758;
      5'd6:    r = 32'sd8387925;
      5'd7:    r = 32'sd4194219;
      5'd8:    r = 32'sd2097141;
      5'd9:    r = 32'sd1048575;
      default: r = 32'sd1 <<< (5'd29 - idx);
    endcase
    return r;
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [DataW-1:0] r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/phe_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phe_ctrl
// Sequencer: product pass, threshold, normalize, CORDIC steps, result.
// ----------------------------------------------------------------------------
module phe_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  phe_pkg::status_t status_i,
  output phe_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_THR, S_SEL, S_NORM, S_ROT, S_ITER, S_FIN
  } state_e;

  state_e     state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o       = '0;
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o.mul_idx  = phe_pkg::mul_idx_e'(cnt_q[2:0]);
    cmd_o.acc_idx  = phe_pkg::mul_idx_e'(3'(cnt_q - 5'd1));
    cmd_o.iter_idx = cnt_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_en = (cnt_q < 5'(phe_pkg::MulN));
        cmd_o.acc_en = (cnt_q != 5'd0);
        cnt_d        = cnt_q + 5'd1;
        if (cnt_q == 5'(phe_pkg::MulN)) begin
          state_d = S_THR;
        end
      end
      S_THR: begin
        cmd_o.thr_mul = 1'b1;
        state_d       = S_SEL;
      end
      S_SEL: begin
        cmd_o.sel = 1'b1;
        state_d   = S_NORM;
      end
      S_NORM: begin
        if (status_i.zero) begin
          state_d = S_FIN;
        end else if (status_i.hi) begin
          cmd_o.shr = 1'b1;
        end else if (status_i.lo) begin
          cmd_o.shl = 1'b1;
        end else begin
          state_d = S_ROT;
        end
      end
      S_ROT: begin
        cmd_o.rot = 1'b1;
        cnt_d     = '0;
        state_d   = S_ITER;
      end
      S_ITER: begin
        cmd_o.iter = 1'b1;
        cnt_d      = cnt_q + 5'd1;
        if (cnt_q == 5'(phe_pkg::Steps - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!status_i.captured) begin
          cmd_o.fin = 1'b1;
          state_d   = S_IDLE;
        end else if (out_free) begin
          cmd_o.fin   = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ITER |-> cnt_q <= 5'(phe_pkg::Steps - 1))
    else $error("CORDIC step count out of range");

  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result valid raised outside finish");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> state_q == S_MUL)
    else $error("accepted beat did not start product pass");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.fin && status_i.captured && out_valid_q && out_stall_i))
    else $error("stalled result overwritten");
`endif

endmodule

@@ hdl/phe_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phe_dp
// Datapath: target registers, shared multiplier, threshold, CORDIC, outputs.
// ----------------------------------------------------------------------------
module phe_dp (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [1:0]              cfg_idx_i,
  input  logic signed [31:0]      cfg_data_i,
  input  logic signed [31:0]      pos_x_i,
  input  logic signed [31:0]      pos_y_i,
  input  logic signed [31:0]      pos_z_i,
  input  logic signed [31:0]      quat_w_i,
  input  logic signed [31:0]      quat_x_i,
  input  logic signed [31:0]      quat_y_i,
  input  logic signed [31:0]      quat_z_i,
  input  logic signed [31:0]      vel_x_i,
  input  logic signed [31:0]      vel_y_i,
  input  logic signed [31:0]      vel_z_i,
  input  phe_pkg::cmd_t           cmd_i,
  output phe_pkg::status_t        status_o,
  output logic signed [31:0]      err_x_o,
  output logic signed [31:0]      err_y_o,
  output logic signed [31:0]      err_z_o,
  output logic signed [31:0]      heading_error_o,
  output logic signed [31:0]      neg_vel_x_o,
  output logic signed [31:0]      neg_vel_y_o,
  output logic signed [31:0]      neg_vel_z_o
);

  typedef enum logic [1:0] {M_GEN, M_POS, M_NEG} mode_e;

  logic signed [31:0] tgt_x_q, tgt_y_q, tgt_z_q, tgt_hdg_q;
  logic               captured_q;
  logic signed [31:0] init_hdg_q;

  logic signed [31:0] px_q, py_q, pz_q, qw_q, qx_q, qy_q, qz_q, vx_q, vy_q, vz_q;
  logic signed [63:0] p_q;
  logic signed [63:0] unit_q, s_q, zx_q, wz_q, xy_q;
  logic [57:0]        t_q;
  logic signed [63:0] x_q, y_q, m_q;
  logic signed [31:0] z_q;
  mode_e              mode_q;

  logic signed [31:0] ma, mb;
  logic signed [63:0] pq;
  logic signed [63:0] thr, num, den, ox, oy, ax, ay;
  logic signed [63:0] xs, ys, yaw, hdg_ref;
  logic signed [31:0] atan_v;

  always_comb begin
    case (cmd_i.mul_idx)
      phe_pkg::MUL_WW: begin ma = qw_q; mb = qw_q; end
      phe_pkg::MUL_XX: begin ma = qx_q; mb = qx_q; end
      phe_pkg::MUL_YY: begin ma = qy_q; mb = qy_q; end
      phe_pkg::MUL_ZZ: begin ma = qz_q; mb = qz_q; end
      phe_pkg::MUL_WX: begin ma = qw_q; mb = qx_q; end
      phe_pkg::MUL_YZ: begin ma = qy_q; mb = qz_q; end
      phe_pkg::MUL_WZ: begin ma = qw_q; mb = qz_q; end
      default:         begin ma = qx_q; mb = qy_q; end
    endcase
  end

  assign pq  = p_q >>> 4;
  assign thr = (unit_q >>> 1) - 64'(t_q >> 20);
  assign num = (wz_q - xy_q) <<< 1;
  assign den = (64'sd1 <<< 56) - (zx_q <<< 1);
  assign ox  = (s_q > thr || s_q < -thr) ? 64'(qw_q) : den;
  assign oy  = (s_q > thr || s_q < -thr) ? 64'(qy_q) : num;
  assign ax  = (ox < 0) ? -ox : ox;
  assign ay  = (oy < 0) ? -oy : oy;

  assign xs     = x_q >>> cmd_i.iter_idx;
  assign ys     = y_q >>> cmd_i.iter_idx;
  assign atan_v = phe_pkg::atan_q29(cmd_i.iter_idx);

  always_comb begin
    case (mode_q)
      M_POS:   yaw = (64'(z_q) + 64'sd2048) >>> 12;
      M_NEG:   yaw = -((64'(z_q) + 64'sd2048) >>> 12);
      default: yaw = (64'(z_q) + 64'sd4096) >>> 13;
    endcase
  end
  assign hdg_ref = 64'(init_hdg_q) + 64'(tgt_hdg_q);

  assign status_o.zero     = (x_q == 64'sd0) && (y_q == 64'sd0);
  assign status_o.hi       = (m_q >= (64'sd1 <<< 30));
  assign status_o.lo       = (m_q < (64'sd1 <<< 29));
  assign status_o.captured = captured_q;

  // Target registers and heading capture state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_x_q    <= '0;
      tgt_y_q    <= '0;
      tgt_z_q    <= phe_pkg::TgtZReset;
      tgt_hdg_q  <= '0;
      captured_q <= 1'b0;
      init_hdg_q <= '0;
    end else begin
      if (cfg_we_i) begin
        captured_q <= 1'b0;
        case (phe_pkg::cfg_reg_e'(cfg_idx_i))
          phe_pkg::REG_TGT_X:   tgt_x_q   <= cfg_data_i;
          phe_pkg::REG_TGT_Y:   tgt_y_q   <= cfg_data_i;
          phe_pkg::REG_TGT_Z:   tgt_z_q   <= cfg_data_i;
          phe_pkg::REG_TGT_HDG: tgt_hdg_q <= cfg_data_i;
          default:              captured_q <= captured_q;
        endcase
      end else if (cmd_i.fin && !captured_q) begin
        captured_q <= 1'b1;
        init_hdg_q <= yaw[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      px_q <= pos_x_i;  py_q <= pos_y_i;  pz_q <= pos_z_i;
      qw_q <= quat_w_i; qx_q <= quat_x_i; qy_q <= quat_y_i; qz_q <= quat_z_i;
      vx_q <= vel_x_i;  vy_q <= vel_y_i;  vz_q <= vel_z_i;
      unit_q <= '0; s_q <= '0; zx_q <= '0; wz_q <= '0; xy_q <= '0;
    end
    if (cmd_i.mul_en) begin
      p_q <= ma * mb;
    end
    if (cmd_i.acc_en) begin
      case (cmd_i.acc_idx)
        phe_pkg::MUL_WW, phe_pkg::MUL_YY: unit_q <= unit_q + pq;
        phe_pkg::MUL_XX, phe_pkg::MUL_ZZ: begin
          unit_q <= unit_q + pq;
          zx_q   <= zx_q + pq;
        end
        phe_pkg::MUL_WX, phe_pkg::MUL_YZ: s_q <= s_q + pq;
        phe_pkg::MUL_WZ:                  wz_q <= pq;
        default:                          xy_q <= pq;
      endcase
    end
    if (cmd_i.thr_mul) begin
      t_q <= 58'(unit_q[60:20]) * 58'(phe_pkg::EpsQ40);
    end
    if (cmd_i.sel) begin
      x_q    <= ox;
      y_q    <= oy;
      m_q    <= (ax > ay) ? ax : ay;
      z_q    <= '0;
      mode_q <= (s_q > thr) ? M_POS : ((s_q < -thr) ? M_NEG : M_GEN);
    end
    if (cmd_i.shr) begin
      x_q <= x_q >>> 1;
      y_q <= y_q >>> 1;
      m_q <= m_q >>> 1;
    end
    if (cmd_i.shl) begin
      x_q <= x_q <<< 1;
      y_q <= y_q <<< 1;
      m_q <= m_q <<< 1;
    end
    // Prerotate into the right half plane
    if (cmd_i.rot && x_q < 0) begin
      if (y_q >= 0) begin
        x_q <= y_q;
        y_q <= -x_q;
        z_q <= 32'(phe_pkg::HalfPiQ29);
      end else begin
        x_q <= -y_q;
        y_q <= x_q;
        z_q <= -32'(phe_pkg::HalfPiQ29);
      end
    end
    if (cmd_i.iter) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + atan_v;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - atan_v;
      end
    end
    if (cmd_i.fin && captured_q) begin
      err_x_o         <= phe_pkg::sat32(64'(px_q) - 64'(tgt_x_q));
      err_y_o         <= phe_pkg::sat32(64'(py_q) - 64'(tgt_y_q));
      err_z_o         <= phe_pkg::sat32(64'(pz_q) - 64'(tgt_z_q));
      heading_error_o <= phe_pkg::sat32(yaw - hdg_ref);
      neg_vel_x_o     <= phe_pkg::sat32(-64'(vx_q));
      neg_vel_y_o     <= phe_pkg::sat32(-64'(vy_q));
      neg_vel_z_o     <= phe_pkg::sat32(-64'(vz_q));
    end
  end

endmodule

@@ hdl/pose_hold_error.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pose_hold_error
// Position and heading hold error from one odometry sample per beat.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes position, quaternion and
// velocity; output channel (out_valid_o / out_stall_i) gives the errors.
// Config writes (cfg_we_i, cfg_idx_i, cfg_data_i) set the target position
// and heading offset; any write rearms heading capture.
// One sample takes a load, the product pass and threshold, then the CORDIC
// operand normalize (a check plus one-bit shifts), a prerotate, 30 CORDIC
// steps on the shared shift/add unit and a finish, the time being set mostly
// by the normalize and CORDIC loops. A pair of zero atan2 operands skips
// to finish.
// One sample is worked on at a time; in_stall_o is high while busy.
// The first sample after reset or a config write only captures the initial
// heading and gives no result beat.
// A finished result waits in the output register while out_stall_i is high;
// the next sample is accepted meanwhile and holds in finish until it drains.
// Reset clears control and restores the target defaults (z target two).
// ----------------------------------------------------------------------------
module pose_hold_error (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic signed [31:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] pos_x_i,
  input  logic signed [31:0] pos_y_i,
  input  logic signed [31:0] pos_z_i,
  input  logic signed [31:0] quat_w_i,
  input  logic signed [31:0] quat_x_i,
  input  logic signed [31:0] quat_y_i,
  input  logic signed [31:0] quat_z_i,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] err_x_o,
  output logic signed [31:0] err_y_o,
  output logic signed [31:0] err_z_o,
  output logic signed [31:0] heading_error_o,
  output logic signed [31:0] neg_vel_x_o,
  output logic signed [31:0] neg_vel_y_o,
  output logic signed [31:0] neg_vel_z_o
);

  phe_pkg::cmd_t    cmd;
  phe_pkg::status_t status;

  phe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  phe_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .quat_w_i        (quat_w_i),
    .quat_x_i        (quat_x_i),
    .quat_y_i        (quat_y_i),
    .quat_z_i        (quat_z_i),
    .vel_x_i         (vel_x_i),
    .vel_y_i         (vel_y_i),
    .vel_z_i         (vel_z_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .err_x_o         (err_x_o),
    .err_y_o         (err_y_o),
    .err_z_o         (err_z_o),
    .heading_error_o (heading_error_o),
    .neg_vel_x_o     (neg_vel_x_o),
    .neg_vel_y_o     (neg_vel_y_o),
    .neg_vel_z_o     (neg_vel_z_o)
  );

endmodule
